// File: design/rti_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and helpers for the ray/triangle intersection unit.
// Depends on nothing; every other file of the unit refers to it by scoped names.
package rti_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int VEC_WIDTH = 3 * COORD_WIDTH;
   localparam int T_WIDTH = 32;
   localparam int T_FRAC = 16;
   localparam int PLANE_EPS_WIDTH = 16;
   localparam int EDGE_EPS_WIDTH = 32;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   // Arithmetic widths derived from the coordinate width.
   localparam int PROD_WIDTH = 2 * COORD_WIDTH;
   localparam int NDIR_WIDTH = 2 * COORD_WIDTH + 2;
   localparam int DIST_WIDTH = 2 * COORD_WIDTH + 3;
   localparam int DIV_WIDTH = 2 * COORD_WIDTH + 2;

   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES = T_WIDTH / DIV_STEPS_PER_STAGE;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PLANE_EPS = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EDGE_EPS = 1'b1;

   localparam logic [PLANE_EPS_WIDTH-1:0] PLANE_EPS_RESET = 16'd1;
   localparam logic [EDGE_EPS_WIDTH-1:0] EDGE_EPS_RESET = 32'd168;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      logic [VEC_WIDTH-1:0] face_normal;
      logic [VEC_WIDTH-1:0] vertex2;
      logic [VEC_WIDTH-1:0] vertex1;
      logic [VEC_WIDTH-1:0] vertex0;
      logic [VEC_WIDTH-1:0] ray_dir;
      logic [VEC_WIDTH-1:0] ray_origin;
   } req_type;

   typedef struct packed {
      logic [VEC_WIDTH-1:0] hit_point;
      logic [T_WIDTH-1:0] hit_distance;
      logic plane_hit;
      logic triangle_hit;
   } rsp_type;

   // One item on its way through the divider.
   typedef struct packed {
      logic hit;
      logic sat;
      logic [DIV_WIDTH-1:0] rem;
      logic [T_WIDTH-1:0] quo;
      logic [DIV_WIDTH-1:0] divisor;
      req_type geom;
   } div_lane_type;

   function automatic coord_type vec_coord(input logic [VEC_WIDTH-1:0] v, input int k);
      return v[k*COORD_WIDTH +: COORD_WIDTH];
   endfunction

endpackage

// File: design/rti_front.sv
`timescale 1ns / 1ps
// Front end: normal dot products, plane test and divider setup, three stages.
// Depends on rti_pkg.
module rti_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     in_valid,
   input  rti_pkg::req_type                         in_data,
   input  logic [rti_pkg::PLANE_EPS_WIDTH-1:0]      plane_eps,
   output logic                                     out_valid,
   output rti_pkg::div_lane_type                    out_lane
);

   localparam int CW = rti_pkg::COORD_WIDTH;
   localparam int PW = rti_pkg::PROD_WIDTH;
   localparam int NW = rti_pkg::NDIR_WIDTH;
   localparam int DW = rti_pkg::DIST_WIDTH;
   localparam int VW = rti_pkg::DIV_WIDTH;
   localparam int TF = rti_pkg::T_FRAC;
   localparam int TW = rti_pkg::T_WIDTH;

   // Stage 1: products.
   logic signed [PW-1:0] pdir_in [3];
   logic signed [PW:0]   pdst_in [3];
   logic signed [PW-1:0] pdir_ff [3];
   logic signed [PW:0]   pdst_ff [3];
   logic signed [CW:0]   delta [3];
   rti_pkg::req_type     geom1_ff;
   logic                 valid1_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         delta[k] = (CW+1)'(rti_pkg::vec_coord(in_data.ray_origin, k))
                  - (CW+1)'(rti_pkg::vec_coord(in_data.vertex0, k));
         pdir_in[k] = rti_pkg::vec_coord(in_data.face_normal, k)
                    * rti_pkg::vec_coord(in_data.ray_dir, k);
         pdst_in[k] = rti_pkg::vec_coord(in_data.face_normal, k) * delta[k];
      end
   end

   // Stage 2: sums and plane test.
   logic signed [NW-1:0] ndir;
   logic signed [DW-1:0] dist_sum;
   logic signed [NW:0]   ndir_eps;
   logic                 hit2_ff;
   logic [VW-1:0]        dist2_ff;
   logic [VW-1:0]        div2_ff;
   rti_pkg::req_type     geom2_ff;
   logic                 valid2_ff;

   always_comb begin
      ndir = NW'(pdir_ff[0]) + NW'(pdir_ff[1]) + NW'(pdir_ff[2]);
      dist_sum = DW'(pdst_ff[0]) + DW'(pdst_ff[1]) + DW'(pdst_ff[2]);
      // Hit when ndir is at most -epsilon and negative, and dist_sum >= 0.
      ndir_eps = (NW+1)'(ndir) + (NW+1)'($signed({1'b0, plane_eps}));
   end

   // Stage 3: saturation check and divider start values.
   // t reaches 2^32 exactly when the distance's integer part reaches the divisor.
   logic sat;
   always_comb begin
      sat = (dist2_ff >> TF) >= div2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         out_valid <= 1'b0;
      end else if (adv) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         out_valid <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pdir_ff  <= pdir_in;
         pdst_ff  <= pdst_in;
         geom1_ff <= in_data;
         hit2_ff  <= ndir[NW-1] & (ndir_eps[NW] | (ndir_eps == '0)) & ~dist_sum[DW-1];
         dist2_ff <= VW'(dist_sum);
         div2_ff  <= VW'(-ndir);
         geom2_ff <= geom1_ff;
         out_lane.hit     <= hit2_ff;
         out_lane.sat     <= sat;
         out_lane.rem     <= dist2_ff >> TF;
         out_lane.quo     <= {dist2_ff[TF-1:0], {(TW-TF){1'b0}}};
         out_lane.divisor <= div2_ff;
         out_lane.geom    <= geom2_ff;
      end
   end

endmodule

// File: design/rti_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for the ray parameter, a fixed number of quotient
// bits per stage. Depends on rti_pkg.
module rti_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  rti_pkg::div_lane_type in_lane,
   output logic                  out_valid,
   output rti_pkg::div_lane_type out_lane
);

   localparam int NS = rti_pkg::DIV_STAGES;
   localparam int VW = rti_pkg::DIV_WIDTH;
   localparam int TW = rti_pkg::T_WIDTH;

   function automatic rti_pkg::div_lane_type div_step(input rti_pkg::div_lane_type l);
      rti_pkg::div_lane_type r;
      logic [VW:0] part;
      r = l;
      part = {l.rem, l.quo[TW-1]};
      r.quo = {l.quo[TW-2:0], 1'b0};
      if (part >= {1'b0, l.divisor}) begin
         part = part - {1'b0, l.divisor};
         r.quo[0] = 1'b1;
      end
      r.rem = part[VW-1:0];
      return r;
   endfunction

   rti_pkg::div_lane_type lane_ff [NS];
   rti_pkg::div_lane_type lane_in [NS];
   logic [NS-1:0]         valid_ff;

   for (genvar s = 0; s < NS; s++) begin : g_stage
      rti_pkg::div_lane_type src;
      if (s == 0) begin : g_first
         assign src = in_lane;
      end else begin : g_next
         assign src = lane_ff[s-1];
      end
      always_comb begin
         lane_in[s] = src;
         for (int j = 0; j < rti_pkg::DIV_STEPS_PER_STAGE; j++) begin
            lane_in[s] = div_step(lane_in[s]);
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            lane_ff[s] <= lane_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NS-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_lane  = lane_ff[NS-1];

endmodule

// File: design/rti_hit.sv
`timescale 1ns / 1ps
// Back end: hit point, edge triple products and result register, six stages.
// Depends on rti_pkg.
module rti_hit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 in_valid,
   input  rti_pkg::div_lane_type                in_lane,
   input  logic [rti_pkg::EDGE_EPS_WIDTH-1:0]   edge_eps,
   output logic                                 out_valid,
   output rti_pkg::rsp_type                     out_data
);

   localparam int CW  = rti_pkg::COORD_WIDTH;
   localparam int VCW = rti_pkg::VEC_WIDTH;
   localparam int TW  = rti_pkg::T_WIDTH;
   localparam int TF  = rti_pkg::T_FRAC;
   localparam int EW  = rti_pkg::EDGE_EPS_WIDTH;
   localparam int TPW = TW + 1 + CW;
   localparam int SPW = TPW - TF + 1;
   localparam int XW  = 2 * CW + 2;
   localparam int MW  = 2 * CW + 3;
   localparam int MNW = MW + CW;
   localparam int SW  = ((MNW + 2) > (EW + 1) ? (MNW + 2) : (EW + 1)) + 1;
   localparam logic signed [SPW-1:0] C_MAX = {{(SPW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SPW-1:0] C_MIN = {{(SPW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   logic [5:0] valid_ff;

   // Stage 1: t times direction.
   logic [TW-1:0]         t_val;
   logic signed [TPW-1:0] tp_in [3];
   logic signed [TPW-1:0] tp1_ff [3];
   logic [TW-1:0]         t1_ff;
   logic                  hit1_ff;
   rti_pkg::req_type      geom1_ff;

   always_comb begin
      t_val = in_lane.sat ? {TW{1'b1}} : in_lane.quo;
      for (int k = 0; k < 3; k++) begin
         tp_in[k] = $signed({1'b0, t_val}) * rti_pkg::vec_coord(in_lane.geom.ray_dir, k);
      end
   end

   // Stage 2: add origin and saturate.
   logic signed [SPW-1:0] psum [3];
   logic [VCW-1:0]        pt_in;
   logic [VCW-1:0]        pt2_ff;
   logic [TW-1:0]         t2_ff;
   logic                  hit2_ff;
   rti_pkg::req_type      geom2_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         psum[k] = SPW'(rti_pkg::vec_coord(geom1_ff.ray_origin, k)) + SPW'(tp1_ff[k] >>> TF);
         if (psum[k] > C_MAX) begin
            psum[k] = C_MAX;
         end else if (psum[k] < C_MIN) begin
            psum[k] = C_MIN;
         end
         pt_in[k*CW +: CW] = psum[k][CW-1:0];
      end
   end

   // Stage 3: edge and offset vectors, cross products.
   logic [VCW-1:0]        side_a [3];
   logic [VCW-1:0]        side_b [3];
   logic signed [CW:0]    dv [3][3];
   logic signed [CW:0]    ev [3][3];
   logic signed [XW-1:0]  xp_in [3][6];
   logic signed [XW-1:0]  xp3_ff [3][6];
   logic [VCW-1:0]        pt3_ff;
   logic [VCW-1:0]        nrm3_ff;
   logic [TW-1:0]         t3_ff;
   logic                  hit3_ff;

   always_comb begin
      side_a[0] = geom2_ff.vertex0;
      side_b[0] = geom2_ff.vertex1;
      side_a[1] = geom2_ff.vertex1;
      side_b[1] = geom2_ff.vertex2;
      side_a[2] = geom2_ff.vertex2;
      side_b[2] = geom2_ff.vertex0;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            dv[i][k] = (CW+1)'(rti_pkg::vec_coord(side_a[i], k))
                     - (CW+1)'(rti_pkg::vec_coord(pt2_ff, k));
            ev[i][k] = (CW+1)'(rti_pkg::vec_coord(side_b[i], k))
                     - (CW+1)'(rti_pkg::vec_coord(side_a[i], k));
         end
         xp_in[i][0] = dv[i][1] * ev[i][2];
         xp_in[i][1] = dv[i][2] * ev[i][1];
         xp_in[i][2] = dv[i][2] * ev[i][0];
         xp_in[i][3] = dv[i][0] * ev[i][2];
         xp_in[i][4] = dv[i][0] * ev[i][1];
         xp_in[i][5] = dv[i][1] * ev[i][0];
      end
   end

   // Stage 4: cross product components.
   logic signed [MW-1:0] m_in [3][3];
   logic signed [MW-1:0] m4_ff [3][3];
   logic [VCW-1:0]       pt4_ff;
   logic [VCW-1:0]       nrm4_ff;
   logic [TW-1:0]        t4_ff;
   logic                 hit4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            m_in[i][k] = MW'(xp3_ff[i][2*k]) - MW'(xp3_ff[i][2*k+1]);
         end
      end
   end

   // Stage 5: products with the normal.
   logic signed [MNW-1:0] mn_in [3][3];
   logic signed [MNW-1:0] mn5_ff [3][3];
   logic [VCW-1:0]        pt5_ff;
   logic [TW-1:0]         t5_ff;
   logic                  hit5_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            mn_in[i][k] = m4_ff[i][k] * rti_pkg::vec_coord(nrm4_ff, k);
         end
      end
   end

   // Stage 6: triple product sums against the tolerance.
   logic signed [SW-1:0] tsum [3];
   logic                 tri_hit;
   rti_pkg::rsp_type     rsp_in;

   always_comb begin
      tri_hit = hit5_ff;
      for (int i = 0; i < 3; i++) begin
         tsum[i] = SW'(mn5_ff[i][0]) + SW'(mn5_ff[i][1]) + SW'(mn5_ff[i][2])
                 + SW'($signed({1'b0, edge_eps}));
         tri_hit = tri_hit & ~tsum[i][SW-1];
      end
      rsp_in.triangle_hit = tri_hit;
      rsp_in.plane_hit    = hit5_ff;
      rsp_in.hit_distance = hit5_ff ? t5_ff : '0;
      rsp_in.hit_point    = tri_hit ? pt5_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tp1_ff   <= tp_in;
         t1_ff    <= t_val;
         hit1_ff  <= in_lane.hit;
         geom1_ff <= in_lane.geom;
         pt2_ff   <= pt_in;
         t2_ff    <= t1_ff;
         hit2_ff  <= hit1_ff;
         geom2_ff <= geom1_ff;
         xp3_ff   <= xp_in;
         pt3_ff   <= pt2_ff;
         nrm3_ff  <= geom2_ff.face_normal;
         t3_ff    <= t2_ff;
         hit3_ff  <= hit2_ff;
         m4_ff    <= m_in;
         pt4_ff   <= pt3_ff;
         nrm4_ff  <= nrm3_ff;
         t4_ff    <= t3_ff;
         hit4_ff  <= hit3_ff;
         mn5_ff   <= mn_in;
         pt5_ff   <= pt4_ff;
         t5_ff    <= t4_ff;
         hit5_ff  <= hit4_ff;
         out_data <= rsp_in;
      end
   end

   assign out_valid = valid_ff[5];

endmodule

// File: design/ray_triangle_intersect_unit.sv
`timescale 1ns / 1ps
// Top level of the ray/triangle intersection unit: input skid, config registers,
// front end, divider and hit back end. Depends on rti_pkg, rti_front, rti_div, rti_hit.
//
//   Channel  Handshake            Payload
//   req      req_valid/req_ready  req_data   (rti_pkg::req_type, ray and triangle)
//   rsp      rsp_valid/rsp_ready  rsp_data   (rti_pkg::rsp_type, hit flags, t, point)
//   csr      csr_write_en         csr_index, csr_wdata (plane and edge tolerance)
//
// One item enters per cycle while the pipeline advances; its result passes 3 front-end
// stages, 16 divider stages at 2 quotient bits each and 6 back-end stages.
// The divider sets the depth: one restoring step per quotient bit of t.
// Reset is synchronous and clears the valid bits and the skid; the tolerances
// return to 1 and 168. When the result is not taken, the whole pipeline holds;
// req_ready comes from a register, and one item arriving in that cycle waits in
// the skid stage.
module ray_triangle_intersect_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  rti_pkg::req_type                        req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output rti_pkg::rsp_type                        rsp_data,
   input  logic                                    csr_write_en,
   input  logic [rti_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [rti_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   logic [rti_pkg::PLANE_EPS_WIDTH-1:0] plane_eps_ff;
   logic [rti_pkg::EDGE_EPS_WIDTH-1:0]  edge_eps_ff;

   // CSR writes are registered; software must only write while idle, not enforced here.
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_eps_ff <= rti_pkg::PLANE_EPS_RESET;
         edge_eps_ff  <= rti_pkg::EDGE_EPS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            rti_pkg::CSR_PLANE_EPS: begin
               plane_eps_ff <= csr_wdata[rti_pkg::PLANE_EPS_WIDTH-1:0];
            end
            rti_pkg::CSR_EDGE_EPS: begin
               edge_eps_ff <= csr_wdata[rti_pkg::EDGE_EPS_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The pipeline moves as a whole whenever the result register is free or being taken.
   logic adv;
   assign adv = ~rsp_valid | rsp_ready;

   // Skid stage: catches the one item accepted in a cycle where the pipeline holds.
   logic             skid_valid_ff;
   rti_pkg::req_type skid_data_ff;
   logic             pipe_in_valid;
   rti_pkg::req_type pipe_in_data;

   assign req_ready     = ~skid_valid_ff;
   assign pipe_in_valid = skid_valid_ff | req_valid;
   assign pipe_in_data  = skid_valid_ff ? skid_data_ff : req_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (adv) begin
         skid_valid_ff <= 1'b0;
      end else if (req_valid & req_ready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (~adv & req_valid & req_ready) begin
         skid_data_ff <= req_data;
      end
   end

   logic                  front_valid;
   rti_pkg::div_lane_type front_lane;
   logic                  div_valid;
   rti_pkg::div_lane_type div_lane;

   rti_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (pipe_in_valid),
      .in_data   (pipe_in_data),
      .plane_eps (plane_eps_ff),
      .out_valid (front_valid),
      .out_lane  (front_lane)
   );

   rti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_lane   (front_lane),
      .out_valid (div_valid),
      .out_lane  (div_lane)
   );

   rti_hit u_hit (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_lane   (div_lane),
      .edge_eps  (edge_eps_ff),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // A missed plane reports nothing else.
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.plane_hit |->
         !rsp_data.triangle_hit && rsp_data.hit_distance == '0)
      else $error("plane miss with nonzero result fields");

   // Inside the triangle implies on the plane ahead.
   a_tri_on_plane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.triangle_hit |-> rsp_data.plane_hit)
      else $error("triangle hit without plane hit");

   // The hit point is only shown for a triangle hit.
   a_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.triangle_hit |-> rsp_data.hit_point == '0)
      else $error("hit point given for a miss");

   // A parked item stays in the skid until the pipeline moves.
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !adv |=> skid_valid_ff && $stable(skid_data_ff))
      else $error("skid item lost during a stall");
`endif

endmodule

// File: bench/tb_ray_triangle_intersect_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for ray_triangle_intersect_unit: directed table, then random phases.
// Depends on rti_pkg and the unit's RTL; expected results are typed-in rows or predicted.
module tb_ray_triangle_intersect_unit;

   typedef longint triple_type [3];

   // One row of the directed table. When known is set, the expected result is typed
   // in; otherwise the predictor supplies it.
   typedef struct {
      rti_pkg::req_type item;
      bit known;
      rti_pkg::rsp_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rti_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rti_pkg::rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [rti_pkg::CSR_INDEX_WIDTH-1:0] csr_index = rti_pkg::CSR_PLANE_EPS;
   logic [rti_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // The bench's own copy of the two tolerance registers.
   longint plane_tol = 1;
   longint edge_tol = 168;

   rti_pkg::rsp_type hit_results_due[$];
   bit typed_known_q[$];
   rti_pkg::rsp_type typed_want_q[$];
   int errors = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_off_cycles = 0;

   ray_triangle_intersect_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [rti_pkg::VEC_WIDTH-1:0] pack3(longint x, longint y, longint z);
      return {z[rti_pkg::COORD_WIDTH-1:0], y[rti_pkg::COORD_WIDTH-1:0],
              x[rti_pkg::COORD_WIDTH-1:0]};
   endfunction

   function automatic void split3(input logic [rti_pkg::VEC_WIDTH-1:0] v,
                                  output triple_type c);
      for (int k = 0; k < 3; k++) begin
         c[k] = $signed(v[k*rti_pkg::COORD_WIDTH +: rti_pkg::COORD_WIDTH]);
      end
   endfunction

   // Edge test: dot(cross(a - p, b - a), n) + tolerance must not be negative.
   // The sums fit comfortably in 64 bits, so no splitting is needed.
   function automatic bit edge_inside(triple_type a, triple_type b, triple_type p,
                                      triple_type n);
      triple_type d, e, m;
      longint s;
      for (int k = 0; k < 3; k++) begin
         d[k] = a[k] - p[k];
         e[k] = b[k] - a[k];
      end
      m[0] = d[1] * e[2] - d[2] * e[1];
      m[1] = d[2] * e[0] - d[0] * e[2];
      m[2] = d[0] * e[1] - d[1] * e[0];
      s = m[0] * n[0] + m[1] * n[1] + m[2] * n[2] + edge_tol;
      return s >= 0;
   endfunction

   // Predicts the hit flags, the Q16.16 distance and the saturated hit point.
   function automatic rti_pkg::rsp_type predict_hit(rti_pkg::req_type r);
      triple_type o, d, a, b, c, n, p;
      longint ndir, start_dist, t, v;
      longint cmax, cmin;
      rti_pkg::rsp_type res;
      res = '0;
      cmax = (64'sd1 <<< (rti_pkg::COORD_WIDTH - 1)) - 1;
      cmin = -(64'sd1 <<< (rti_pkg::COORD_WIDTH - 1));
      split3(r.ray_origin, o);
      split3(r.ray_dir, d);
      split3(r.vertex0, a);
      split3(r.vertex1, b);
      split3(r.vertex2, c);
      split3(r.face_normal, n);
      ndir = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
      // A ray that is parallel to, or moving away from, the plane misses it.
      if (ndir > -plane_tol || ndir >= 0) return res;
      start_dist = (n[0] * o[0] + n[1] * o[1] + n[2] * o[2])
                 - (n[0] * a[0] + n[1] * a[1] + n[2] * a[2]);
      if (start_dist < 0) return res;
      t = (start_dist <<< rti_pkg::T_FRAC) / (-ndir);
      if (t > 64'sh0FFFF_FFFF) t = 64'sh0FFFF_FFFF;
      for (int k = 0; k < 3; k++) begin
         v = o[k] + ((t * d[k]) >>> rti_pkg::T_FRAC);
         if (v > cmax) v = cmax;
         if (v < cmin) v = cmin;
         p[k] = v;
      end
      res.plane_hit = 1'b1;
      res.hit_distance = t[rti_pkg::T_WIDTH-1:0];
      if (edge_inside(a, b, p, n) && edge_inside(b, c, p, n) && edge_inside(c, a, p, n)) begin
         res.triangle_hit = 1'b1;
         res.hit_point = pack3(p[0], p[1], p[2]);
      end
      return res;
   endfunction

   // Input monitor: every accepted item gets its expected result queued, either the
   // typed-in value of a directed row or the predictor's answer.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (typed_known_q.size() != 0) begin
            if (typed_known_q.pop_front()) begin
               hit_results_due.push_back(typed_want_q.pop_front());
            end else begin
               void'(typed_want_q.pop_front());
               hit_results_due.push_back(predict_hit(req_data));
            end
         end else begin
            hit_results_due.push_back(predict_hit(req_data));
         end
      end
   end

   // Result side: random stalls, an optional long hold-off, and the field-by-field check.
   always @(posedge clock) begin
      rti_pkg::rsp_type want;
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (hit_results_due.size() == 0) begin
            $display("%0t: item with no expectation waiting, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = hit_results_due.pop_front();
            if (rsp_data.triangle_hit !== want.triangle_hit) begin
               $display("%0t: triangle_hit expected %b actual %b", $time,
                        want.triangle_hit, rsp_data.triangle_hit);
               errors++;
            end
            if (rsp_data.plane_hit !== want.plane_hit) begin
               $display("%0t: plane_hit expected %b actual %b", $time,
                        want.plane_hit, rsp_data.plane_hit);
               errors++;
            end
            if (rsp_data.hit_distance !== want.hit_distance) begin
               $display("%0t: hit_distance expected %h actual %h", $time,
                        want.hit_distance, rsp_data.hit_distance);
               errors++;
            end
            if (rsp_data.hit_point !== want.hit_point) begin
               $display("%0t: hit_point expected %h actual %h", $time,
                        want.hit_point, rsp_data.hit_point);
               errors++;
            end
         end
      end
   end

   // Offers one item after a random idle gap and returns at the edge that accepts it.
   // The ready flag is sampled at the falling edge, where it is stable.
   task automatic offer_item(rti_pkg::req_type item);
      bit taken;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Waits until every expected item is back and the pipe is quiet, then writes both
   // tolerance registers, the plane register first.
   task automatic set_tolerances(longint plane_value, longint edge_value);
      req_valid <= 1'b0;
      while (hit_results_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= rti_pkg::CSR_PLANE_EPS;
      // Upper bits are set on purpose; the plane register keeps only its low 16 bits.
      csr_wdata <= {16'($urandom), plane_value[15:0]};
      @(posedge clock);
      csr_index <= rti_pkg::CSR_EDGE_EPS;
      csr_wdata <= edge_value[31:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      plane_tol = plane_value & 64'hFFFF;
      edge_tol = edge_value & 64'hFFFF_FFFF;
   endtask

   function automatic longint span(int half);
      return longint'($urandom_range(2 * half)) - half;
   endfunction

   // Mostly well-formed scenes: a small triangle, its normal from the edge cross
   // product, and a ray aimed near the centroid. A quarter is pure noise.
   function automatic rti_pkg::req_type random_item();
      rti_pkg::req_type r;
      triple_type a, b, c, o, n;
      longint tx, ty, tz;
      if ($urandom_range(3) == 0) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom};
         return r;
      end
      for (int k = 0; k < 3; k++) begin
         a[k] = span(512);
         b[k] = span(512);
         c[k] = span(512);
         o[k] = span(1024);
      end
      n[0] = ((b[1] - a[1]) * (c[2] - a[2]) - (b[2] - a[2]) * (c[1] - a[1])) >>> 8;
      n[1] = ((b[2] - a[2]) * (c[0] - a[0]) - (b[0] - a[0]) * (c[2] - a[2])) >>> 8;
      n[2] = ((b[0] - a[0]) * (c[1] - a[1]) - (b[1] - a[1]) * (c[0] - a[0])) >>> 8;
      if ($urandom_range(1)) for (int k = 0; k < 3; k++) n[k] = -n[k];
      tx = (a[0] + b[0] + c[0]) / 3 + span(128);
      ty = (a[1] + b[1] + c[1]) / 3 + span(128);
      tz = (a[2] + b[2] + c[2]) / 3 + span(128);
      r.ray_origin = pack3(o[0], o[1], o[2]);
      r.ray_dir = pack3(tx - o[0], ty - o[1], tz - o[2]);
      r.vertex0 = pack3(a[0], a[1], a[2]);
      r.vertex1 = pack3(b[0], b[1], b[2]);
      r.vertex2 = pack3(c[0], c[1], c[2]);
      r.face_normal = pack3(n[0], n[1], n[2]);
      return r;
   endfunction

   initial begin
      row_type rows[10];
      rti_pkg::req_type base;
      int idle_set[6] = '{0, 63, 0, 19, 0, 0};
      int stall_set[6] = '{0, 0, 63, 19, 0, 0};
      longint plane_set[6];
      longint edge_set[6];

      // A unit triangle in z = 0, facing +z, with vertices counterclockwise.
      base.vertex0 = pack3(0, 0, 0);
      base.vertex1 = pack3(256, 0, 0);
      base.vertex2 = pack3(0, 256, 0);
      base.face_normal = pack3(0, 0, 256);
      base.ray_dir = pack3(0, 0, -256);
      base.ray_origin = pack3(64, 64, 256);

      // All-zero item: zero divisor, so the plane is missed.
      rows[0] = '{'0, 1'b1, '0};
      // Every bit set: normal and direction both point the same way, a miss.
      rows[1] = '{'1, 1'b1, '0};
      // Straight down onto the triangle from one unit above: t is exactly 1.0.
      rows[2] = '{base, 1'b1, '0};
      rows[2].want.triangle_hit = 1'b1;
      rows[2].want.plane_hit = 1'b1;
      rows[2].want.hit_distance = 32'h0001_0000;
      rows[2].want.hit_point = pack3(64, 64, 0);
      // Origin below the plane: negative distance, a miss.
      rows[3] = '{base, 1'b1, '0};
      rows[3].item.ray_origin = pack3(64, 64, -256);
      // Plane hit but the point lies outside the triangle.
      rows[4] = '{base, 1'b0, '0};
      rows[4].item.ray_origin = pack3(512, 64, 256);
      // Point exactly on the edge x = 0, and one step outside it.
      rows[5] = '{base, 1'b0, '0};
      rows[5].item.ray_origin = pack3(0, 64, 256);
      rows[6] = '{base, 1'b0, '0};
      rows[6].item.ray_origin = pack3(-1, 64, 256);
      // Largest and smallest coordinates in every field.
      rows[7] = '{{6{16'h7FFF, 16'h7FFF, 16'h7FFF}}, 1'b0, '0};
      rows[8] = '{{6{16'h8000, 16'h8000, 16'h8000}}, 1'b0, '0};
      // Nearly parallel ray from far away: t and the hit point both saturate.
      rows[9] = '{base, 1'b0, '0};
      rows[9].item.face_normal = pack3(1, 32767, 0);
      rows[9].item.ray_dir = pack3(-1, 0, 0);
      rows[9].item.ray_origin = pack3(0, 32767, 0);

      plane_set = '{1, 0, 65535, longint'($urandom_range(65535)), 300, 1};
      edge_set = '{168, 0, 64'hFFFF_FFFF, longint'($urandom), 1 << 20, 168};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The directed table runs under the reset tolerances and again with both at zero.
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1) set_tolerances(0, 0);
         foreach (rows[i]) begin
            typed_known_q.push_back(rows[i].known);
            typed_want_q.push_back(rows[i].want);
            offer_item(rows[i].item);
         end
      end

      // Random phases, each with its own idling pattern and tolerance setting. The
      // fifth holds the result side off for a long stretch so the pipe fills up.
      for (int ph = 0; ph < 6; ph++) begin
         set_tolerances(plane_set[ph], edge_set[ph]);
         sender_idle_pct = idle_set[ph];
         receiver_stall_pct = stall_set[ph];
         if (ph == 4) hold_off_cycles = 300;
         for (int i = 0; i < 140; i++) offer_item(random_item());
      end
      req_valid <= 1'b0;

      while (hit_results_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Guards against a hung handshake.
   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
design/rti_pkg.sv
design/rti_front.sv
design/rti_div.sv
design/rti_hit.sv
design/ray_triangle_intersect_unit.sv
bench/tb_ray_triangle_intersect_unit.sv
